// ===== hdl/ngga_pkg.sv =====
// shared types, status codes and constants of the gga fix parser
`timescale 1ns / 1ps

package ngga_pkg;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HDR   = 3'd1;
  localparam logic [2:0] ST_NO_FIX    = 3'd2;
  localparam logic [2:0] ST_MEM_NOLCK = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  // widest scaled-minutes value over the whole parameter range
  localparam int MIN_W_MAX = 24;

  // reciprocal of sixty, exact for dividends below 2^36 / 44
  localparam int             RECIP_SHIFT = 36;
  localparam logic [30:0]    RECIP_60    = 31'd1145324613;
  localparam logic [23:0]    DEG_SCALE   = 24'd10000000;
  localparam logic [29:0]    LAT_MAX     = 30'd900000000;
  localparam logic [30:0]    LON_MAX     = 31'd1800000000;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [29:0]        latitude;
    logic signed [31:0] longitude;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic               fix_locked_out;
  } out_t;

  // one decided sentence, captured values with the local hour, zero when rejected
  typedef struct packed {
    logic [2:0]           status;
    logic                 locked;
    logic [6:0]           lat_deg;
    logic [MIN_W_MAX-1:0] lat_min;
    logic [9:0]           lon_deg;
    logic [MIN_W_MAX-1:0] lon_min;
    logic [4:0]           hour;
    logic [5:0]           minute;
    logic [5:0]           second;
  } job_t;

  // expected header text, one character per position
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h47;
      3'd4:    ch = 8'h47;
      3'd5:    ch = 8'h41;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/ngga_fifo.sv =====
// small first-in first-out queue with occupancy count
`timescale 1ns / 1ps

module ngga_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == LW'(DEPTH));
  assign level   = cnt_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/ngga_front.sv =====
// character front end: field tracking, digit capture and result decision
`timescale 1ns / 1ps

module ngga_front import ngga_pkg::*; #(
  parameter int MIN_FRAC_DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  in_t        in_data,
  input  logic [4:0] hour_offset,
  output logic       job_valid,
  output job_t       job
);

  localparam int MW = $clog2(10 ** (MIN_FRAC_DIGITS + 2));
  localparam int VW = MW + 4;
  localparam logic [MW-1:0] MIN_CAP   = MW'(10 ** (MIN_FRAC_DIGITS + 2) - 1);
  localparam logic [MW-1:0] MIN_SCALE = MW'(10 ** MIN_FRAC_DIGITS);

  localparam logic [2:0] FLD_HDR  = 3'd0;
  localparam logic [2:0] FLD_TIME = 3'd1;
  localparam logic [2:0] FLD_LAT  = 3'd2;
  localparam logic [2:0] FLD_LON  = 3'd4;
  localparam logic [2:0] FLD_QUAL = 3'd6;
  localparam logic [2:0] FLD_LAST = 3'd7;

  localparam logic [1:0] QC_EMPTY = 2'd0;
  localparam logic [1:0] QC_ZERO  = 2'd1;
  localparam logic [1:0] QC_SEVEN = 2'd2;
  localparam logic [1:0] QC_OTHER = 2'd3;

  localparam logic [2:0] FRAC_STOP = 3'd7;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [6:0] HR_CAP = 7'd23;
  localparam logic [6:0] MI_CAP = 7'd59;
  localparam logic [6:0] SE_CAP = 7'd60;
  localparam logic [4:0] OFF_CAP = 5'd23;

  // bit 3 set when the field end decides a result, bits 2:0 the status
  function automatic logic [3:0] end_eval(input logic [2:0] fld, input logic [4:0] cif,
                                          input logic hok, input logic [1:0] qc,
                                          input logic lk);
    logic [3:0] r;
    r = 4'b0000;
    if (fld == FLD_HDR) begin
      if (!(hok && cif == 5'd6)) r = {1'b1, ST_BAD_HDR};
    end else if (fld == FLD_QUAL) begin
      if (qc == QC_EMPTY || qc == QC_ZERO) r = {1'b1, ST_NO_FIX};
      else if (qc == QC_SEVEN && !lk)     r = {1'b1, ST_MEM_NOLCK};
      else                                 r = {1'b1, ST_OK};
    end
    return r;
  endfunction

  // fraction digit weights, indexed by the digit's place after the point
  logic [MW-1:0] frac_wt [8];
  for (genvar g = 0; g < 8; g++) begin : g_wt
    if (g >= 1 && g <= MIN_FRAC_DIGITS) begin : g_on
      assign frac_wt[g] = MW'(10 ** (MIN_FRAC_DIGITS - g));
    end else begin : g_off
      assign frac_wt[g] = '0;
    end
  end

  logic [2:0]    field_r, field_nxt;
  logic [4:0]    cif_r, cif_nxt;
  logic          done_r, done_nxt;
  logic          hdr_ok_r, hdr_ok_nxt;
  logic [4:0]    tim_hr_r, tim_hr_nxt;
  logic [5:0]    tim_mi_r, tim_mi_nxt;
  logic [5:0]    tim_se_r, tim_se_nxt;
  logic [6:0]    lat_deg_r, lat_deg_nxt;
  logic [MW-1:0] lat_min_r, lat_min_nxt;
  logic [9:0]    lon_deg_r, lon_deg_nxt;
  logic [MW-1:0] lon_min_r, lon_min_nxt;
  logic [2:0]    frac_r, frac_nxt;
  logic          seen_r, seen_nxt;
  logic [1:0]    qual_r, qual_nxt;
  logic          locked_r, locked_nxt;

  logic [7:0]    ch;
  logic          last, dig, is_comma;
  logic [3:0]    dval;
  logic [4:0]    pos, cif_inc;

  // time pair capture
  logic [6:0]    t_old, t_cap, t_mul, t_new;
  logic          t_seen;

  // coordinate capture
  logic          is_lon;
  logic [4:0]    ndeg;
  logic [9:0]    deg_old, deg_new;
  logic [MW-1:0] min_old, min_new;
  logic [VW-1:0] mins_sum;
  logic          c_seen;
  logic [2:0]    c_frac;

  logic [3:0]    res1, res2;
  logic          res_has, clr;
  logic [2:0]    res_status;

  logic [4:0]    off;
  logic [5:0]    hr_loc;
  logic          ok;

  assign ch       = in_data.char_byte;
  assign last     = in_data.last_byte;
  assign dig      = (ch >= CH_0) && (ch <= CH_9);
  assign dval     = ch[3:0];
  assign is_comma = (ch == CH_COMMA);
  assign pos      = cif_r;
  assign cif_inc  = (cif_r == 5'd31) ? cif_r : cif_r + 1'b1;

  always_comb begin
    unique case (pos[2:1])
      2'd0: begin
        t_old = 7'(tim_hr_r);
        t_cap = HR_CAP;
      end
      2'd1: begin
        t_old = 7'(tim_mi_r);
        t_cap = MI_CAP;
      end
      default: begin
        t_old = 7'(tim_se_r);
        t_cap = SE_CAP;
      end
    endcase
    t_mul  = (t_old << 3) + (t_old << 1) + 7'(dval);
    t_new  = t_old;
    t_seen = seen_r;
    if (!pos[0]) begin
      t_new  = dig ? 7'(dval) : '0;
      t_seen = !dig;
    end else if (!seen_r && dig) begin
      t_new = (t_mul > t_cap) ? t_cap : t_mul;
    end
  end

  always_comb begin
    is_lon   = (field_r == FLD_LON);
    ndeg     = is_lon ? 5'd3 : 5'd2;
    deg_old  = is_lon ? lon_deg_r : 10'(lat_deg_r);
    min_old  = is_lon ? lon_min_r : lat_min_r;
    deg_new  = deg_old;
    min_new  = min_old;
    c_seen   = seen_r;
    c_frac   = frac_r;
    mins_sum = VW'(min_old);
    if (pos < ndeg) begin
      if (!seen_r && dig) deg_new = (deg_old << 3) + (deg_old << 1) + 10'(dval);
      else                c_seen  = 1'b1;
    end else begin
      if (pos == ndeg) begin
        c_seen = 1'b0;
        c_frac = '0;
      end
      if (c_frac != FRAC_STOP) begin
        if (dig) begin
          if (!c_seen) begin
            mins_sum = (VW'(min_old) << 3) + (VW'(min_old) << 1)
                     + VW'(dval) * VW'(MIN_SCALE);
          end else if (c_frac < 3'(MIN_FRAC_DIGITS)) begin
            c_frac   = c_frac + 1'b1;
            mins_sum = VW'(min_old) + VW'(dval) * VW'(frac_wt[c_frac]);
          end
          min_new = (mins_sum > VW'(MIN_CAP)) ? MIN_CAP : mins_sum[MW-1:0];
        end else if (ch == CH_POINT && !c_seen) begin
          c_seen = 1'b1;
        end else begin
          c_frac = FRAC_STOP;
        end
      end
    end
  end

  always_comb begin
    field_nxt   = field_r;
    cif_nxt     = cif_r;
    done_nxt    = done_r;
    hdr_ok_nxt  = hdr_ok_r;
    tim_hr_nxt  = tim_hr_r;
    tim_mi_nxt  = tim_mi_r;
    tim_se_nxt  = tim_se_r;
    lat_deg_nxt = lat_deg_r;
    lat_min_nxt = lat_min_r;
    lon_deg_nxt = lon_deg_r;
    lon_min_nxt = lon_min_r;
    frac_nxt    = frac_r;
    seen_nxt    = seen_r;
    qual_nxt    = qual_r;
    locked_nxt  = locked_r;
    res1        = '0;
    res2        = '0;
    res_has     = 1'b0;
    res_status  = ST_OK;
    clr         = 1'b0;
    if (take) begin
      if (done_r) begin
        clr = last;
      end else begin
        if (is_comma) begin
          res1 = end_eval(field_r, cif_r, hdr_ok_r, qual_r, locked_r);
          if (!res1[3]) begin
            field_nxt = (field_r == FLD_LAST) ? field_r : field_r + 1'b1;
            cif_nxt   = '0;
            seen_nxt  = 1'b0;
            frac_nxt  = '0;
          end
        end else begin
          unique case (field_r)
            FLD_HDR: begin
              if (pos >= 5'd6 || ch != hdr_char(pos[2:0])) hdr_ok_nxt = 1'b0;
            end
            FLD_TIME: begin
              if (pos <= 5'd5) begin
                seen_nxt = t_seen;
                unique case (pos[2:1])
                  2'd0:    tim_hr_nxt = t_new[4:0];
                  2'd1:    tim_mi_nxt = t_new[5:0];
                  default: tim_se_nxt = t_new[5:0];
                endcase
              end
            end
            FLD_LAT, FLD_LON: begin
              seen_nxt = c_seen;
              frac_nxt = c_frac;
              if (is_lon) begin
                lon_deg_nxt = deg_new;
                lon_min_nxt = min_new;
              end else begin
                lat_deg_nxt = deg_new[6:0];
                lat_min_nxt = min_new;
              end
            end
            FLD_QUAL: begin
              if (pos == '0) begin
                qual_nxt = (ch == CH_0) ? QC_ZERO : ((ch == CH_7) ? QC_SEVEN : QC_OTHER);
              end else begin
                qual_nxt = QC_OTHER;
              end
            end
            default: ;
          endcase
          cif_nxt = cif_inc;
        end
        // final beat closes whatever field is open
        if (!res1[3] && last) begin
          res2 = end_eval(field_nxt, cif_nxt, hdr_ok_nxt, qual_nxt, locked_r);
        end
        priority if (res1[3]) begin
          res_has    = 1'b1;
          res_status = res1[2:0];
        end else if (res2[3]) begin
          res_has    = 1'b1;
          res_status = res2[2:0];
        end else if (last) begin
          res_has    = 1'b1;
          res_status = ST_TRUNC;
        end
        if (res_has && res_status == ST_OK) locked_nxt = 1'b1;
        if (last)         clr      = 1'b1;
        else if (res_has) done_nxt = 1'b1;
      end
    end
    if (clr) begin
      field_nxt   = '0;
      cif_nxt     = '0;
      done_nxt    = 1'b0;
      hdr_ok_nxt  = 1'b1;
      tim_hr_nxt  = '0;
      tim_mi_nxt  = '0;
      tim_se_nxt  = '0;
      lat_deg_nxt = '0;
      lat_min_nxt = '0;
      lon_deg_nxt = '0;
      lon_min_nxt = '0;
      frac_nxt    = '0;
      seen_nxt    = 1'b0;
      qual_nxt    = QC_EMPTY;
    end
  end

  // local hour, offset above 23 acts as 23
  assign off    = (hour_offset > OFF_CAP) ? OFF_CAP : hour_offset;
  assign hr_loc = (tim_hr_r >= off) ? 6'(tim_hr_r - off) : 6'(tim_hr_r) + 6'd24 - 6'(off);
  assign ok     = (res_status == ST_OK);

  assign job_valid   = take && !done_r && res_has;
  assign job.status  = res_status;
  assign job.locked  = locked_nxt;
  assign job.lat_deg = ok ? lat_deg_r : '0;
  assign job.lat_min = ok ? MIN_W_MAX'(lat_min_r) : '0;
  assign job.lon_deg = ok ? lon_deg_r : '0;
  assign job.lon_min = ok ? MIN_W_MAX'(lon_min_r) : '0;
  assign job.hour    = ok ? hr_loc[4:0] : '0;
  assign job.minute  = ok ? tim_mi_r : '0;
  assign job.second  = ok ? tim_se_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r   <= '0;
      cif_r     <= '0;
      done_r    <= 1'b0;
      hdr_ok_r  <= 1'b1;
      tim_hr_r  <= '0;
      tim_mi_r  <= '0;
      tim_se_r  <= '0;
      lat_deg_r <= '0;
      lat_min_r <= '0;
      lon_deg_r <= '0;
      lon_min_r <= '0;
      frac_r    <= '0;
      seen_r    <= 1'b0;
      qual_r    <= QC_EMPTY;
      locked_r  <= 1'b0;
    end else begin
      field_r   <= field_nxt;
      cif_r     <= cif_nxt;
      done_r    <= done_nxt;
      hdr_ok_r  <= hdr_ok_nxt;
      tim_hr_r  <= tim_hr_nxt;
      tim_mi_r  <= tim_mi_nxt;
      tim_se_r  <= tim_se_nxt;
      lat_deg_r <= lat_deg_nxt;
      lat_min_r <= lat_min_nxt;
      lon_deg_r <= lon_deg_nxt;
      lon_min_r <= lon_min_nxt;
      frac_r    <= frac_nxt;
      seen_r    <= seen_nxt;
      qual_r    <= qual_nxt;
      locked_r  <= locked_nxt;
    end
  end

endmodule

// ===== hdl/ngga_back.sv =====
// conversion back end: three-stage pipeline from raw capture to 1e-7 degree units
`timescale 1ns / 1ps

module ngga_back import ngga_pkg::*; #(
  parameter int MIN_FRAC_DIGITS = 4,
  parameter int OUT_DEPTH       = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_avail,
  input  job_t                           job,
  output logic                           job_take,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_level,
  output logic                           res_valid,
  output out_t                           res
);

  localparam int MW = $clog2(10 ** (MIN_FRAC_DIGITS + 2));
  localparam int LW = $clog2(OUT_DEPTH + 1);
  localparam int XW = 30;
  localparam int PW = XW + 31;
  localparam int KV = 10 ** (7 - MIN_FRAC_DIGITS);
  localparam int KW = $clog2(KV + 1);
  localparam logic [KW-1:0] KC = KW'(KV);

  typedef struct packed {
    logic [2:0] status;
    logic       locked;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } meta_t;

  logic          v1_r, v2_r, v3_r;
  meta_t         m1_r, m2_r;
  logic [XW-1:0] a_lat_r, a_lon_r;
  logic [29:0]   c_lat1_r, c_lat2_r;
  logic [33:0]   c_lon1_r, c_lon2_r;
  logic [23:0]   q_lat_r, q_lon_r;
  out_t          res_r;

  logic [LW:0]   used;
  logic [MW-1:0] lat_min, lon_min;
  logic [PW-1:0] p_lat, p_lon;
  logic [30:0]   s_lat;
  logic [34:0]   s_lon;
  logic [30:0]   lon_mag;
  meta_t         m0;

  // results in flight plus results queued never exceed the result queue
  assign used     = (LW + 1)'(out_level) + (LW + 1)'(v1_r) + (LW + 1)'(v2_r)
                  + (LW + 1)'(v3_r);
  assign job_take = job_avail && (used < (LW + 1)'(OUT_DEPTH));

  assign lat_min = job.lat_min[MW-1:0];
  assign lon_min = job.lon_min[MW-1:0];
  assign m0      = '{status: job.status, locked: job.locked, hour: job.hour,
                     minute: job.minute, second: job.second};

  assign p_lat   = PW'(a_lat_r) * PW'(RECIP_60);
  assign p_lon   = PW'(a_lon_r) * PW'(RECIP_60);

  assign s_lat   = 31'(c_lat2_r) + 31'(q_lat_r);
  assign s_lon   = 35'(c_lon2_r) + 35'(q_lon_r);
  assign lon_mag = (s_lon > 35'(LON_MAX)) ? LON_MAX : s_lon[30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= job_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: scale fractional minutes, degrees to units
    m1_r     <= m0;
    a_lat_r  <= XW'(lat_min) * XW'(KC);
    a_lon_r  <= XW'(lon_min) * XW'(KC);
    c_lat1_r <= 30'(job.lat_deg) * 30'(DEG_SCALE);
    c_lon1_r <= 34'(job.lon_deg) * 34'(DEG_SCALE);
    // stage 2: divide by sixty through the reciprocal
    m2_r     <= m1_r;
    q_lat_r  <= p_lat[RECIP_SHIFT+23:RECIP_SHIFT];
    q_lon_r  <= p_lon[RECIP_SHIFT+23:RECIP_SHIFT];
    c_lat2_r <= c_lat1_r;
    c_lon2_r <= c_lon1_r;
    // stage 3: sum, saturate, negate longitude
    res_r.status         <= m2_r.status;
    res_r.latitude       <= (s_lat > 31'(LAT_MAX)) ? LAT_MAX : s_lat[29:0];
    res_r.longitude      <= 32'sd0 - signed'(32'(lon_mag));
    res_r.hour           <= m2_r.hour;
    res_r.minute         <= m2_r.minute;
    res_r.second         <= m2_r.second;
    res_r.fix_locked_out <= m2_r.locked;
  end

  assign res_valid = v3_r;
  assign res       = res_r;

endmodule

// ===== hdl/nmea_gga_fix_parser_unit.sv =====
// top level of the gga fix parser: front end, job queue, back end, result queue
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// --------  ---------  -------------------  ----------------------------------
// input     in         push / full          in_data  (char_byte, last_byte)
// result    out        empty / pop          out_data (status .. fix_locked_out)
// config    in         cfg_valid/cfg_ready  cfg_data (hour_offset, 5 bits)
//
// one character beat is taken every cycle while full is low; a sentence gives
// at most one result, which reaches out_data through the job queue, the three
// conversion stages and the result queue
// reset is synchronous and clears all control state at once, no clearing pass
// full rises only when the job queue is full; the back end stops taking jobs
// while the pipeline and the result queue together hold OUT_DEPTH results

module nmea_gga_fix_parser_unit import ngga_pkg::*; #(
  parameter int MIN_FRAC_DIGITS = 4,
  parameter int JOB_DEPTH       = 2,
  parameter int OUT_DEPTH       = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  // character beats
  input  logic       push,
  output logic       full,
  input  in_t        in_data,
  // result beats
  output logic       empty,
  input  logic       pop,
  output out_t       out_data,
  // hour offset register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  localparam int JW = $bits(job_t);
  localparam int OW = $bits(out_t);
  localparam int LW = $clog2(OUT_DEPTH + 1);

  logic [4:0]    hour_offset_r, hour_offset_nxt;

  logic          take;
  logic          job_push;
  job_t          job_in, job_out;
  logic [JW-1:0] job_out_bits;
  logic          job_empty, job_full, job_take;

  logic          res_valid;
  out_t          res;
  logic [OW-1:0] out_bits;
  logic [LW-1:0] out_level;
  logic          out_full;

  // the register is always ready; the user must write it only while the block is idle, the block does not enforce it
  assign cfg_ready       = 1'b1;
  assign hour_offset_nxt = (cfg_valid && cfg_ready) ? cfg_data : hour_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_offset_r <= 5'd5;
    end else begin
      hour_offset_r <= hour_offset_nxt;
    end
  end

  // a beat is taken whenever the job queue has room for what it may decide
  assign full = job_full;
  assign take = push && !job_full;

  ngga_front #(
    .MIN_FRAC_DIGITS(MIN_FRAC_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_data    (in_data),
    .hour_offset(hour_offset_r),
    .job_valid  (job_push),
    .job        (job_in)
  );

  // decouples the character side from the conversion pipeline
  ngga_fifo #(
    .WIDTH(JW),
    .DEPTH(JOB_DEPTH)
  ) u_job_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (job_push),
    .wdata(job_in),
    .pop  (job_take),
    .rdata(job_out_bits),
    .empty(job_empty),
    .full (job_full),
    .level()
  );

  assign job_out = job_t'(job_out_bits);

  ngga_back #(
    .MIN_FRAC_DIGITS(MIN_FRAC_DIGITS),
    .OUT_DEPTH      (OUT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_avail(!job_empty),
    .job      (job_out),
    .job_take (job_take),
    .out_level(out_level),
    .res_valid(res_valid),
    .res      (res)
  );

  // results wait here until popped
  ngga_fifo #(
    .WIDTH(OW),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_valid),
    .wdata(res),
    .pop  (pop),
    .rdata(out_bits),
    .empty(empty),
    .full (out_full),
    .level(out_level)
  );

  assign out_data = out_t'(out_bits);

  // credit scheme must keep the pipeline from ever meeting a full result queue
  a_no_out_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !out_full)
    else $error("result written into a full result queue");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // an accepted fix always leaves the lock set
  a_ok_locked: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status == ST_OK) |-> out_data.fix_locked_out)
    else $error("accepted fix without lock");

  // rejected sentences carry zero position
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status != ST_OK) |->
      (out_data.latitude == '0 && out_data.longitude == '0))
    else $error("rejected sentence with non-zero position");

endmodule

// ===== tb/sv/tb_nmea_gga_fix_parser_unit.sv =====
// self-checking testbench of the gga fix parser: directed sentences, then random phases
`timescale 1ns / 1ps

module tb_nmea_gga_fix_parser_unit;
  import ngga_pkg::*;

  // run control
  localparam int LIMIT_CYCLES = 200000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 20;      // extra wait once every owed fix is collected
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 90;      // character beats per random phase

  // sentence field numbers
  localparam bit [2:0] F_HEADER  = 3'd0;
  localparam bit [2:0] F_TIME    = 3'd1;
  localparam bit [2:0] F_LAT     = 3'd2;
  localparam bit [2:0] F_LON     = 3'd4;
  localparam bit [2:0] F_QUALITY = 3'd6;
  localparam bit [2:0] F_LAST    = 3'd7;

  // coordinate arithmetic, minutes are held times ten to the fraction digits
  localparam int          FRAC_DIGITS = 4;
  localparam int          FRAC_STOP   = 7;       // number ended by a stray character
  localparam int unsigned FRAC_SCALE  = 10000;
  localparam int unsigned MIN_CAP     = 999999;
  localparam int unsigned MIN_DEN     = 600000;  // sixty minutes at that scale
  localparam int unsigned HOUR_TOP    = 23;
  localparam int          LAT_AXIS    = 0;
  localparam int          LON_AXIS    = 1;
  localparam int          NO_DECISION = -1;

  localparam bit [7:0] CH_COMMA = ",";
  localparam bit [7:0] CH_POINT = ".";
  localparam bit [7:0] CH_ZERO  = "0";
  localparam bit [7:0] CH_SEVEN = "7";
  localparam bit [7:0] CH_NINE  = "9";

  typedef enum bit [1:0] {Q_EMPTY, Q_ZERO, Q_MEMORY, Q_OTHER} quality_e;
  typedef bit [7:0] text_q [$];

  // ---------------------------------------------------------------------------
  // sentence predictor and store of fixes still owed by the block
  // ---------------------------------------------------------------------------
  class gga_scoreboard;
    bit [4:0]  hour_off;
    bit [2:0]  fld;
    bit [4:0]  cif;
    bit        done;
    bit        hdr_ok;
    bit        seen_pt;
    bit        locked;
    bit [16:0] time_acc;   // hour 16..12, minute 11..6, second 5..0
    bit [9:0]  deg_acc [2];
    bit [19:0] min_acc [2];
    bit [2:0]  frac;
    quality_e  qual;
    out_t      fix;
    out_t      fixes_due [$];
    int        errors;
    string     header_text;

    function new();
      header_text = "$GPGGA";
      hour_off    = 5'd5;
      locked      = 1'b0;
      errors      = 0;
      clear_line();
    endfunction

    function void clear_line();
      fld      = F_HEADER;
      cif      = '0;
      done     = 1'b0;
      hdr_ok   = 1'b1;
      seen_pt  = 1'b0;
      time_acc = '0;
      deg_acc  = '{default: '0};
      min_acc  = '{default: '0};
      frac     = '0;
      qual     = Q_EMPTY;
    endfunction

    // two characters per time part, leading digits only
    function void take_time(int unsigned pos, bit [7:0] c, bit dig);
      int unsigned p;
      int unsigned v;
      int unsigned sh;
      int unsigned msk;
      int unsigned lim;
      if (pos > 5) return;
      p   = pos >> 1;
      sh  = (p == 0) ? 12 : ((p == 1) ? 6 : 0);
      msk = (p == 0) ? 31 : 63;
      lim = (p == 0) ? 23 : ((p == 1) ? 59 : 60);
      v   = (time_acc >> sh) & msk;
      if (pos % 2 == 0) begin
        v       = dig ? (c - CH_ZERO) : 0;
        seen_pt = !dig;
      end else if (!seen_pt && dig) begin
        v = v * 10 + (c - CH_ZERO);
        if (v > lim) v = lim;
      end
      time_acc = 17'((time_acc & ~(msk << sh)) | (v << sh));
    endfunction

    function void take_coord(int unsigned pos, bit [7:0] c, bit dig, int axis);
      longint unsigned v;
      int unsigned     ndeg;
      int unsigned     weight [5];
      weight = '{10000, 1000, 100, 10, 1};
      ndeg   = (axis == LON_AXIS) ? 3 : 2;
      if (pos < ndeg) begin
        if (!seen_pt && dig) deg_acc[axis] = 10'(deg_acc[axis] * 10 + (c - CH_ZERO));
        else seen_pt = 1'b1;
        return;
      end
      if (pos == ndeg) begin
        seen_pt = 1'b0;
        frac    = '0;
      end
      if (frac == FRAC_STOP) return;
      v = min_acc[axis];
      if (dig) begin
        if (!seen_pt) begin
          v = v * 10 + (c - CH_ZERO) * FRAC_SCALE;
        end else if (frac < FRAC_DIGITS) begin
          frac++;
          v += (c - CH_ZERO) * weight[frac];
        end
        if (v > MIN_CAP) v = MIN_CAP;
        min_acc[axis] = 20'(v);
      end else if (c == CH_POINT && !seen_pt) begin
        seen_pt = 1'b1;
      end else begin
        frac = 3'(FRAC_STOP);
      end
    endfunction

    function longint unsigned to_units(longint unsigned deg, longint unsigned mins,
                                       longint unsigned lim);
      longint unsigned v;
      v = ((deg * MIN_DEN + mins) * 64'd10000000) / MIN_DEN;
      return (v > lim) ? lim : v;
    endfunction

    // status when the field just closed decides the sentence
    function int close_field();
      longint unsigned lon_mag;
      int unsigned     h;
      int unsigned     off;
      if (fld == F_HEADER) begin
        if (hdr_ok && cif == 6) return NO_DECISION;
        return ST_BAD_HDR;
      end
      if (fld != F_QUALITY) return NO_DECISION;
      if (qual == Q_EMPTY || qual == Q_ZERO) return ST_NO_FIX;
      if (qual == Q_MEMORY && !locked) return ST_MEM_NOLCK;
      locked       = 1'b1;
      fix.latitude = 30'(to_units(deg_acc[LAT_AXIS], min_acc[LAT_AXIS], LAT_MAX));
      lon_mag      = to_units(deg_acc[LON_AXIS], min_acc[LON_AXIS], LON_MAX);
      fix.longitude = 32'(64'd0 - lon_mag);
      h   = time_acc[16:12];
      off = (hour_off > HOUR_TOP) ? HOUR_TOP : hour_off;
      fix.hour   = 5'((h >= off) ? (h - off) : (h + 24 - off));
      fix.minute = time_acc[11:6];
      fix.second = time_acc[5:0];
      return ST_OK;
    endfunction

    // one accepted character beat; returns 1 when it owes a fix
    function bit note_char(bit [7:0] c, bit last);
      int          r;
      int unsigned pos;
      bit          dig;
      dig = (c >= CH_ZERO && c <= CH_NINE);
      if (done) begin
        if (last) clear_line();
        return 1'b0;
      end
      fix = '0;
      r   = NO_DECISION;
      if (c == CH_COMMA) begin
        r = close_field();
        if (r == NO_DECISION) begin
          if (fld < F_LAST) fld++;
          cif     = '0;
          seen_pt = 1'b0;
          frac    = '0;
        end
      end else begin
        pos = cif;
        case (fld)
          F_HEADER: begin
            if (pos >= 6 || header_text[pos] != c) hdr_ok = 1'b0;
          end
          F_TIME: take_time(pos, c, dig);
          F_LAT:  take_coord(pos, c, dig, LAT_AXIS);
          F_LON:  take_coord(pos, c, dig, LON_AXIS);
          F_QUALITY: begin
            if (pos == 0) qual = (c == CH_ZERO) ? Q_ZERO : ((c == CH_SEVEN) ? Q_MEMORY : Q_OTHER);
            else qual = Q_OTHER;
          end
          default: ;
        endcase
        if (cif < 31) cif++;
      end
      if (r == NO_DECISION && last) begin
        r = close_field();
        if (r == NO_DECISION) r = ST_TRUNC;
      end
      if (last) clear_line();
      else if (r != NO_DECISION) done = 1'b1;
      if (r == NO_DECISION) return 1'b0;
      fix.status         = r[2:0];
      fix.fix_locked_out = locked;
      fixes_due.push_back(fix);
      return 1'b1;
    endfunction

    function void cmp_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_fix(out_t got);
      out_t want;
      if (fixes_due.size() == 0) begin
        $error("result beat with no fix owed, status %0d", got.status);
        errors++;
        return;
      end
      want = fixes_due.pop_front();
      cmp_field("status", want.status, got.status);
      cmp_field("latitude", want.latitude, got.latitude);
      cmp_field("longitude", want.longitude, got.longitude);
      cmp_field("hour", want.hour, got.hour);
      cmp_field("minute", want.minute, got.minute);
      cmp_field("second", want.second, got.second);
      cmp_field("fix_locked_out", want.fix_locked_out, got.fix_locked_out);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block under test, every input known from time zero
  // ---------------------------------------------------------------------------
  logic       clk;
  logic       rst_n     = 1'b0;
  logic       push      = 1'b0;
  logic       full;
  in_t        in_data   = '0;
  logic       empty;
  logic       pop       = 1'b0;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data  = '0;

  gga_scoreboard sb;
  int idle_pct   = 0;   // chance per cycle that the sender holds off
  int stall_pct  = 0;   // chance per cycle that the receiver holds off
  int beats_sent = 0;

  nmea_gga_fix_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case a beat never gets through
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("nmea_gga_fix_parser_unit test failed");
    $finish;
  end

  // result side: values sampled at the edge are the ones before it
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) sb.check_fix(out_data);
      pop <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // one character beat, held until full is seen low at an edge
  task automatic send_beat(bit [7:0] c, bit last);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= '{char_byte: c, last_byte: last};
    do @(posedge clk); while (full);
    void'(sb.note_char(c, last));
    beats_sent++;
  endtask

  // the final character carries the end mark
  task automatic send_line(text_q t);
    foreach (t[i]) send_beat(t[i], i == t.size() - 1);
  endtask

  // the offset is only written with nothing in flight
  task automatic write_offset(bit [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    sb.hour_off  = v;
  endtask

  // stop sending, collect every fix owed, then let the pipeline empty
  task automatic settle();
    push <= 1'b0;
    while (sb.fixes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sentence text
  // ---------------------------------------------------------------------------
  function automatic text_q to_text(string s);
    text_q t;
    foreach (s[i]) t.push_back(s[i]);
    return t;
  endfunction

  function automatic string pick_chars(string pool, int n);
    string s;
    int    k;
    s = "";
    repeat (n) begin
      k = $urandom_range(pool.len() - 1);
      s = {s, pool.substr(k, k)};
    end
    return s;
  endfunction

  function automatic string digits(int n);
    return pick_chars("0123456789", n);
  endfunction

  function automatic string coord_text(int ndeg, int deg_top);
    string s;
    string deg_s;
    if (ndeg == 3) deg_s = $sformatf("%03d", $urandom_range(deg_top));
    else           deg_s = $sformatf("%02d", $urandom_range(deg_top));
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        s = $sformatf("%s%02d.%s", deg_s, $urandom_range(59), digits($urandom_range(6)));
      end
      6:       s = $sformatf("%s%02d", deg_s, $urandom_range(59));
      7:       s = digits($urandom_range(14));
      default: s = pick_chars("0123456789.-+ eE", $urandom_range(1, 12));
    endcase
    return s;
  endfunction

  // mostly well-formed sentences with random content, the rest broken or noise
  function automatic text_q random_line();
    text_q t;
    string s;
    string time_s;
    string qual_s;
    string tail_s;
    int    kind;
    kind = $urandom_range(99);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        time_s = $sformatf("%02d%02d%02d", $urandom_range(23), $urandom_range(59),
                           $urandom_range(60));
      end
      6: begin
        time_s = $sformatf("%02d%02d%02d.%s", $urandom_range(23), $urandom_range(59),
                           $urandom_range(60), digits(2));
      end
      7:       time_s = digits($urandom_range(8));
      default: time_s = pick_chars("0123456789.:-+ a", $urandom_range(8));
    endcase
    case ($urandom_range(9))
      0, 1, 2: qual_s = "1";
      3:       qual_s = "2";
      4:       qual_s = "0";
      5:       qual_s = "";
      6, 7:    qual_s = "7";
      8:       qual_s = "12";
      default: qual_s = pick_chars("0123456789A*", $urandom_range(1, 3));
    endcase
    case ($urandom_range(3))
      0:       tail_s = "";
      1:       tail_s = ",";
      2:       tail_s = ",08,0.9,545.4,M,46.9,M,,*47";
      default: tail_s = {",", pick_chars("0123456789,.M*", $urandom_range(1, 10))};
    endcase
    s = {"$GPGGA,", time_s, ",", coord_text(2, 90), ",", pick_chars("NS", 1), ",",
         coord_text(3, 180), ",", pick_chars("EW", 1), ",", qual_s, tail_s};
    t = to_text(s);
    if (kind < 65) begin
      // an odd character dropped in now and then
      if ($urandom_range(99) < 15) t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255));
    end else if (kind < 78) begin
      t = t[0:$urandom_range(t.size() - 1)];
    end else if (kind < 90) begin
      if ($urandom_range(1)) t[$urandom_range(5)] = 8'($urandom_range(255));
      else t.insert($urandom_range(6), 8'($urandom_range(255)));
    end else begin
      if (kind < 95) t.delete();
      else t = to_text("$GPGGA,");
      repeat ($urandom_range(1, 24))
        t.push_back(($urandom_range(3) == 0) ? CH_COMMA : 8'($urandom_range(255)));
    end
    return t;
  endfunction

  // hand-picked sentences at the default offset of five hours
  task automatic directed_lines();
    text_q t;
    // memory fix before any lock, rest of the sentence ignored
    send_line(to_text("$GPGGA,123519,4807.038,N,01131.000,E,7,08,0.9,545.4,M,46.9,M,,*47"));
    // zero coordinates, hour five comes out as zero, takes the lock
    send_line(to_text("$GPGGA,050000,0000.0000,N,00000.0000,E,1,08"));
    // memory fix now locked, top of every range, hour wraps to 23
    send_line(to_text("$GPGGA,045960,9000.0000,S,18000.0000,W,7,"));
    // everything saturates, extra fraction digits dropped, decided on the final beat
    send_line(to_text("$GPGGA,999999,9999.9999999,N,99999.99999,E,2"));
    // odd time and coordinate text, two-character quality
    send_line(to_text("$GPGGA,1a2b3,4-07.5.3,N, 12.5e3,E,12,,,"));
    send_line(to_text("$GPGGA,12.5,48+07,N,123..45,E,70"));
    // bad headers
    send_line(to_text("$GPGGB,123519,4807.038,N,01131.000,E,1"));
    send_line(to_text("$GPGGAX,123519,1"));
    send_line(to_text("$GPGG,,,,,,1"));
    send_line(to_text(","));
    send_line(to_text("$"));
    send_line(to_text("$GPGGAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAA"));
    // no fix: quality zero, empty quality, trailing comma into the quality field
    send_line(to_text("$GPGGA,123519,4807.038,N,01131.000,E,0,08"));
    send_line(to_text("$GPGGA,,,,,,,08"));
    send_line(to_text("$GPGGA,,,,,,"));
    // sentences that end early
    send_line(to_text("$GPGGA,1234,56"));
    send_line(to_text("$GPGGA"));
    send_line(to_text("$GPGGA,"));
    // byte zero and byte ff as ordinary characters
    t = to_text("$GPGGA,12,34,N,567,E,1");
    t[13] = 8'h00;
    send_line(t);
    t[2] = 8'h00;
    send_line(t);
    t = to_text("$GPGGA,235959,1234.5678,N,12345.6789,E,1,x");
    t[t.size() - 1] = 8'hff;
    send_line(t);
    // fields far longer than the character counter
    send_line(to_text({"$GPGGA,120000,12345678901234567890123456789012345678901,N,",
                       "1234567890123456789012345678901234567890,W,1"}));
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit [4:0] phase_offset [PHASES];
    int       start_beats;
    phase_offset = '{5'd0, 5'd23, 5'd31, 5'd24, 5'd12, 5'd0, 5'd23, 5'd17};
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct  = 12;
    stall_pct = 12;
    directed_lines();
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_offset(phase_offset[p]);
      // none, sender gaps, receiver stalls, both
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 57; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      start_beats = beats_sent;
      while (beats_sent - start_beats < PHASE_BEATS) send_line(random_line());
      settle();
    end

    if (sb.errors == 0) begin
      $display("nmea_gga_fix_parser_unit test passed");
    end else begin
      $display("nmea_gga_fix_parser_unit test failed");
    end
    $finish;
  end

endmodule
